[src/free_band_gap_search_macros.svh]
// Assertion macros for the free band gap search block.
// Used by the top level only; no other dependencies.
`ifndef FREE_BAND_GAP_SEARCH_MACROS_SVH
`define FREE_BAND_GAP_SEARCH_MACROS_SVH
// Condition must hold on every clock edge outside reset.
`define FBGS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("check failed: label");
// Antecedent implies consequent on the following edge.
`define FBGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: label");
`endif

[src/fbgs_pkg.sv]
// Shared types and constants for the free band gap search block.
// No dependencies.
package fbgs_pkg;
  localparam int MAX_INTERVALS_DEF = 32;
  localparam int MAX_BANDS_DEF = 3;
  localparam int IDX_W = 6;

  localparam logic [1:0] REG_ROAD_LOWER = 2'd0;
  localparam logic [1:0] REG_ROAD_UPPER = 2'd1;
  localparam logic [1:0] REG_BAND_LIMIT = 2'd2;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [IDX_W-1:0]   idx;
  } ent_t;

  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;
endpackage

[src/fbgs_cell.sv]
// One cell of the sorted interval chain: holds one interval in sorted order.
// Depends on fbgs_pkg.
module fbgs_cell (
  input  logic              clk,
  input  fbgs_pkg::cell_ctl_t ctl,
  input  logic              valid_i,
  input  logic              before_prev,
  input  fbgs_pkg::ent_t    new_d,
  input  fbgs_pkg::ent_t    prev_d,
  input  fbgs_pkg::ent_t    next_d,
  output logic              before_o,
  output fbgs_pkg::ent_t    q
);
  fbgs_pkg::ent_t q_r, q_nxt;

  assign before_o = !valid_i || (new_d.lo < q_r.lo) ||
                    ((new_d.lo == q_r.lo) && (new_d.hi > q_r.hi));

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins && before_o) begin
      q_nxt = before_prev ? prev_d : new_d;
    end else if (ctl.rot) begin
      q_nxt = next_d;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;
endmodule

[src/free_band_gap_search.sv]
// Top level of the free band gap search block: interval chain and split scan.
// Depends on fbgs_pkg, fbgs_cell and free_band_gap_search_macros.svh.
//
// Usage: intervals arrive on the in_ channel, one item per cycle while
// in_stall is low, and are inserted into a sorted chain of cells as they
// come. The item with case_end set closes the case; in_stall then stays
// high while the split scan runs. Each scan pass rotates the chain once,
// one split per cycle. One pass finds the first widest band and each
// further pass finds the next ranked band, so a case takes k+1 passes,
// with k ranked bands, each pass ending in one result item.
// Each result item waits in the output register while out_stall is high;
// the next pass starts once it is taken. The last item carries run_end, and
// the block then takes input again. cfg_ready is always high; write
// registers only while the block is idle. Synchronous reset clears the
// count, the flags and the registers to their defaults.
`include "free_band_gap_search_macros.svh"
module free_band_gap_search #(
  parameter int MAX_INTERVALS = fbgs_pkg::MAX_INTERVALS_DEF,
  parameter int MAX_BANDS = fbgs_pkg::MAX_BANDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_interval_low,
  input  logic signed [31:0] in_interval_high,
  input  logic               in_has_interval,
  input  logic               in_case_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_record_kind,
  output logic [1:0]         out_rank,
  output logic [5:0]         out_split,
  output logic signed [31:0] out_band_lower,
  output logic signed [31:0] out_band_upper,
  output logic signed [32:0] out_band_width,
  output logic [31:0]        out_direction_mask,
  output logic               out_overflow,
  output logic               out_bad_input,
  output logic               out_run_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int PW = $clog2(MAX_BANDS + 1);

  fbgs_pkg::state_t state_r, state_nxt;
  logic signed [31:0] road_lo_r, road_up_r;
  logic [1:0] blim_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt, bad_r, bad_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [PW-1:0] pass_r, pass_nxt;
  logic signed [31:0] run_r, run_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic have_r, have_nxt;
  logic [CW-1:0] bs_r, bs_nxt;
  logic signed [31:0] blo_r, blo_nxt, bhi_r, bhi_nxt;
  logic signed [32:0] bwd_r, bwd_nxt;
  logic [34:0] bdist_r, bdist_nxt;
  logic [31:0] bmask_r, bmask_nxt;
  logic [CW-1:0] tk_r [MAX_BANDS];

  fbgs_pkg::cell_ctl_t ctl;
  fbgs_pkg::ent_t new_d;
  fbgs_pkg::ent_t cq [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] ins_here;

  logic accept, do_ins, cand_ok, taken, better, out_take;
  logic signed [31:0] up_c;
  logic signed [32:0] wd_c;
  logic signed [34:0] diff_c;
  logic [34:0] dist_c;
  logic [PW-1:0] k_c;
  logic [32:0] wd_chk;

  assign accept = in_valid && !in_stall;
  assign do_ins = accept && in_has_interval && (cnt_r < CW'(MAX_INTERVALS));
  assign in_stall = (state_r != fbgs_pkg::ST_LOAD);
  assign cfg_ready = 1'b1;
  assign new_d = '{lo: in_interval_low, hi: in_interval_high,
                   idx: fbgs_pkg::IDX_W'(cnt_r)};
  assign ctl.ins = do_ins;
  assign ctl.rot = (state_r == fbgs_pkg::ST_SCAN) && (s_r != CW'(MAX_INTERVALS));

  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    fbgs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid_i    (CW'(i) < cnt_r),
      .before_prev((i == 0) ? 1'b0 : ins_here[(i == 0) ? 0 : i - 1]),
      .new_d      (new_d),
      .prev_d     (cq[(i == 0) ? 0 : i - 1]),
      .next_d     (cq[(i + 1) % MAX_INTERVALS]),
      .before_o   (ins_here[i]),
      .q          (cq[i])
    );
  end

  always_comb begin
    int lim;
    lim = int'(blim_r);
    if (lim > MAX_BANDS) lim = MAX_BANDS;
    if (lim > int'(cnt_r) + 1) lim = int'(cnt_r) + 1;
    k_c = PW'(lim);
  end

  assign cand_ok = (s_r <= cnt_r);
  assign up_c = ((s_r < cnt_r) && (cq[0].lo < road_up_r)) ? cq[0].lo : road_up_r;
  assign wd_c = {up_c[31], up_c} - {run_r[31], run_r};
  assign diff_c = {{3{run_r[31]}}, run_r} + {{3{up_c[31]}}, up_c} -
                  {{3{road_lo_r[31]}}, road_lo_r} - {{3{road_up_r[31]}}, road_up_r};
  assign dist_c = diff_c[34] ? 35'(-diff_c) : 35'(diff_c);

  always_comb begin
    taken = 1'b0;
    for (int j = 0; j < MAX_BANDS; j++) begin
      if ((j + 1 < int'(pass_r)) && (tk_r[j] == s_r)) taken = 1'b1;
    end
  end

  always_comb begin
    if (pass_r == '0) begin
      better = !have_r || (wd_c > bwd_r);
    end else begin
      better = !taken && (!have_r || (wd_c > bwd_r) ||
               ((wd_c == bwd_r) && (dist_c < bdist_r)));
    end
  end

  assign out_take = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    bad_nxt = bad_r;
    s_nxt = s_r;
    pass_nxt = pass_r;
    run_nxt = run_r;
    mask_nxt = mask_r;
    have_nxt = have_r;
    bs_nxt = bs_r;
    blo_nxt = blo_r;
    bhi_nxt = bhi_r;
    bwd_nxt = bwd_r;
    bdist_nxt = bdist_r;
    bmask_nxt = bmask_r;
    unique case (state_r)
      fbgs_pkg::ST_LOAD: begin
        if (accept) begin
          if (in_has_interval) begin
            if (in_interval_low > in_interval_high) bad_nxt = 1'b1;
            if (do_ins) cnt_nxt = cnt_r + 1'b1;
            else ovf_nxt = 1'b1;
          end
          if (in_case_end) begin
            if (road_lo_r > road_up_r) bad_nxt = 1'b1;
            state_nxt = fbgs_pkg::ST_SCAN;
            s_nxt = '0;
            pass_nxt = '0;
            run_nxt = road_lo_r;
            mask_nxt = '0;
            have_nxt = 1'b0;
          end
        end
      end
      fbgs_pkg::ST_SCAN: begin
        if (cand_ok && better) begin
          have_nxt = 1'b1;
          bs_nxt = s_r;
          blo_nxt = run_r;
          bhi_nxt = up_c;
          bwd_nxt = wd_c;
          bdist_nxt = dist_c;
          bmask_nxt = mask_r;
        end
        if (s_r < cnt_r) begin
          if (cq[0].hi > run_r) run_nxt = cq[0].hi;
          if (!cq[0].idx[5]) mask_nxt = mask_r | (32'd1 << cq[0].idx[4:0]);
        end
        if (s_r == CW'(MAX_INTERVALS)) state_nxt = fbgs_pkg::ST_EMIT;
        else s_nxt = s_r + 1'b1;
      end
      fbgs_pkg::ST_EMIT: begin
        if (out_take) begin
          if (out_run_end) begin
            state_nxt = fbgs_pkg::ST_LOAD;
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            bad_nxt = 1'b0;
          end else begin
            state_nxt = fbgs_pkg::ST_SCAN;
            pass_nxt = pass_r + 1'b1;
            s_nxt = '0;
            run_nxt = road_lo_r;
            mask_nxt = '0;
            have_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = fbgs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbgs_pkg::ST_LOAD;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      bad_r <= 1'b0;
      pass_r <= '0;
      road_lo_r <= '0;
      road_up_r <= '0;
      blim_r <= 2'd3;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      bad_r <= bad_nxt;
      pass_r <= pass_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fbgs_pkg::REG_ROAD_LOWER: road_lo_r <= cfg_data;
          fbgs_pkg::REG_ROAD_UPPER: road_up_r <= cfg_data;
          fbgs_pkg::REG_BAND_LIMIT: blim_r <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    run_r <= run_nxt;
    mask_r <= mask_nxt;
    have_r <= have_nxt;
    bs_r <= bs_nxt;
    blo_r <= blo_nxt;
    bhi_r <= bhi_nxt;
    bwd_r <= bwd_nxt;
    bdist_r <= bdist_nxt;
    bmask_r <= bmask_nxt;
    if (state_r == fbgs_pkg::ST_EMIT && out_take && pass_r != '0) begin
      tk_r[pass_r - 1'b1] <= bs_r;
    end
  end

  assign out_valid = (state_r == fbgs_pkg::ST_EMIT);
  assign out_record_kind = (pass_r != '0);
  assign out_rank = (pass_r == '0) ? 2'd0 : 2'(pass_r - 1'b1);
  assign out_split = 6'(bs_r);
  assign out_band_lower = blo_r;
  assign out_band_upper = bhi_r;
  assign out_band_width = bwd_r;
  assign out_direction_mask = bmask_r;
  assign out_overflow = ovf_r;
  assign out_bad_input = bad_r;
  assign out_run_end = (pass_r == k_c);

  assign wd_chk = {out_band_upper[31], out_band_upper} - {out_band_lower[31], out_band_lower};

  `FBGS_ASSERT_ALWAYS(a_stall_busy, clk, rst_n, !out_valid || in_stall)
  `FBGS_ASSERT_ALWAYS(a_kind_rank, clk, rst_n, !out_valid || out_record_kind || out_rank == 2'd0)
  `FBGS_ASSERT_NEXT(a_end_idle, clk, rst_n, out_valid && out_run_end && !out_stall, !out_valid && !in_stall)
  `FBGS_ASSERT_ALWAYS(a_width, clk, rst_n, !out_valid || out_band_width == wd_chk)
endmodule

[tb/tb.sv]
// Self-checking testbench for free_band_gap_search: directed and random intervals per case.
// A scoreboard class predicts the band records; depends on fbgs_pkg and the RTL.
`timescale 1ns / 100ps
module tb;

  typedef struct {
    bit               kind;
    bit [1:0]         rank;
    bit [5:0]         split;
    bit signed [31:0] lower;
    bit signed [31:0] upper;
    bit signed [32:0] width;
    bit [31:0]        mask;
    bit               ovf;
    bit               bad;
    bit               last;
  } band_rec_t;

  class band_scoreboard;
    longint lows[fbgs_pkg::MAX_INTERVALS_DEF];
    longint highs[fbgs_pkg::MAX_INTERVALS_DEF];
    int order[fbgs_pkg::MAX_INTERVALS_DEF];
    int count;
    bit ovf;
    bit bad;
    longint road_lo;
    longint road_hi;
    int limit;
    band_rec_t expected[$];
    int errors;
    int checked;
    int cases;
    longint blo[fbgs_pkg::MAX_INTERVALS_DEF + 1];
    longint bhi[fbgs_pkg::MAX_INTERVALS_DEF + 1];
    longint bwd[fbgs_pkg::MAX_INTERVALS_DEF + 1];

    function new();
      count = 0; ovf = 0; bad = 0; road_lo = 0; road_hi = 0; limit = 3;
      errors = 0; checked = 0; cases = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      if (idx == fbgs_pkg::REG_ROAD_LOWER) road_lo = longint'($signed(data));
      else if (idx == fbgs_pkg::REG_ROAD_UPPER) road_hi = longint'($signed(data));
      else if (idx == fbgs_pkg::REG_BAND_LIMIT) limit = data[1:0];
    endfunction

    function bit sorts_first(int a, int b);
      if (lows[a] != lows[b]) return lows[a] < lows[b];
      if (highs[a] != highs[b]) return highs[a] > highs[b];
      return a < b;
    endfunction

    function longint centre_off(int s);
      longint d;
      d = blo[s] + bhi[s] - road_lo - road_hi;
      return d < 0 ? -d : d;
    endfunction

    function bit ranks_first(int a, int b);
      if (bwd[a] != bwd[b]) return bwd[a] > bwd[b];
      if (centre_off(a) != centre_off(b)) return centre_off(a) < centre_off(b);
      return a < b;
    endfunction

    function void push_band(bit kind, int rank, int s, bit last);
      band_rec_t r;
      r.kind = kind; r.rank = rank; r.split = s;
      r.lower = blo[s]; r.upper = bhi[s]; r.width = bwd[s];
      r.mask = '0;
      for (int i = 0; i < s; i++) r.mask[order[i]] = 1'b1;
      r.ovf = ovf; r.bad = bad; r.last = last;
      expected.insert(expected.size(), r);
    endfunction

    function void note_input(logic [31:0] lo, logic [31:0] hi, bit has, bit ce);
      longint run;
      longint up;
      int j;
      int widest;
      int k;
      int best;
      bit taken[fbgs_pkg::MAX_INTERVALS_DEF + 1];
      if (has) begin
        if ($signed(lo) > $signed(hi)) bad = 1;
        if (count < fbgs_pkg::MAX_INTERVALS_DEF) begin
          lows[count] = longint'($signed(lo));
          highs[count] = longint'($signed(hi));
          count++;
        end else begin
          ovf = 1;
        end
      end
      if (!ce) return;
      cases++;
      if (road_lo > road_hi) bad = 1;
      for (int i = 0; i < count; i++) begin
        j = i;
        while (j > 0 && sorts_first(i, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      run = road_lo;
      for (int s = 0; s <= count; s++) begin
        up = road_hi;
        if (s < count && lows[order[s]] < up) up = lows[order[s]];
        blo[s] = run; bhi[s] = up; bwd[s] = up - run;
        if (s < count && highs[order[s]] > run) run = highs[order[s]];
        taken[s] = 0;
      end
      widest = 0;
      for (int s = 1; s <= count; s++) if (bwd[s] > bwd[widest]) widest = s;
      k = limit;
      if (k > fbgs_pkg::MAX_BANDS_DEF) k = fbgs_pkg::MAX_BANDS_DEF;
      if (k > count + 1) k = count + 1;
      push_band(0, 0, widest, k == 0);
      for (int r = 0; r < k; r++) begin
        best = -1;
        for (int s = 0; s <= count; s++)
          if (!taken[s] && (best < 0 || ranks_first(s, best))) best = s;
        taken[best] = 1;
        push_band(1, r, best, r + 1 == k);
      end
      count = 0; ovf = 0; bad = 0;
    endfunction

    function void check_result(band_rec_t a);
      band_rec_t e;
      if (expected.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      e = expected.pop_front();
      checked++;
      if (a.kind != e.kind) begin
        $error("record_kind exp %0d got %0d", e.kind, a.kind); errors++;
      end
      if (a.rank != e.rank) begin
        $error("rank exp %0d got %0d", e.rank, a.rank); errors++;
      end
      if (a.split != e.split) begin
        $error("split exp %0d got %0d", e.split, a.split); errors++;
      end
      if (a.lower != e.lower) begin
        $error("band_lower exp %0d got %0d", e.lower, a.lower); errors++;
      end
      if (a.upper != e.upper) begin
        $error("band_upper exp %0d got %0d", e.upper, a.upper); errors++;
      end
      if (a.width != e.width) begin
        $error("band_width exp %0d got %0d", e.width, a.width); errors++;
      end
      if (a.mask != e.mask) begin
        $error("direction_mask exp %h got %h", e.mask, a.mask); errors++;
      end
      if (a.ovf != e.ovf) begin
        $error("overflow exp %0d got %0d", e.ovf, a.ovf); errors++;
      end
      if (a.bad != e.bad) begin
        $error("bad_input exp %0d got %0d", e.bad, a.bad); errors++;
      end
      if (a.last != e.last) begin
        $error("run_end exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_interval_low = '0;
  logic signed [31:0] in_interval_high = '0;
  logic in_has_interval = 0;
  logic in_case_end = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_record_kind;
  logic [1:0] out_rank;
  logic [5:0] out_split;
  logic signed [31:0] out_band_lower;
  logic signed [31:0] out_band_upper;
  logic signed [32:0] out_band_width;
  logic [31:0] out_direction_mask;
  logic out_overflow;
  logic out_bad_input;
  logic out_run_end;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  band_scoreboard sb = new();
  int random_items = 0;

  free_band_gap_search dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_item(logic [31:0] lo, logic [31:0] hi, bit has, bit ce);
    int gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(9);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_interval_low <= lo;
    in_interval_high <= hi;
    in_has_interval <= has;
    in_case_end <= ce;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_input(lo, hi, has, ce);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    in_valid <= 0;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_road(logic [31:0] lo, logic [31:0] hi, logic [1:0] lim);
    settle();
    write_reg(fbgs_pkg::REG_ROAD_LOWER, lo);
    write_reg(fbgs_pkg::REG_ROAD_UPPER, hi);
    write_reg(fbgs_pkg::REG_BAND_LIMIT, lim);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_pos(logic [31:0] span);
    case ($urandom_range(3))
      0: return $urandom();
      1: return ($urandom_range(4) - 2) << 16;
      default: return $signed(sb.road_lo) + ($urandom() % (span + 1));
    endcase
  endfunction

  task automatic random_case();
    int n;
    logic [31:0] a, b, t, span;
    n = $urandom_range(15) == 0 ? $urandom_range(35, 30) : $urandom_range(6);
    span = (sb.road_hi > sb.road_lo) ? 32'(sb.road_hi - sb.road_lo) : 32'h10000;
    for (int i = 0; i < n; i++) begin
      a = pick_pos(span);
      b = pick_pos(span);
      if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) begin
        t = a; a = b; b = t;
      end
      if ($urandom_range(12) == 0) send_item($urandom(), $urandom(), 0, 0);
      if (i == n - 1 && $urandom_range(1)) send_item(a, b, 1, 1);
      else send_item(a, b, 1, 0);
      random_items++;
    end
    if (n == 0 || sb.cases == 0 || sb.count != 0) begin
      send_item($urandom(), $urandom(), 0, 1);
      random_items++;
    end
  endtask

  always begin
    int gap;
    band_rec_t got;
    @(posedge clk);
    while (rst_n) begin
      gap = $urandom_range(3) == 0 ? 0 : $urandom_range(9);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      do @(negedge clk); while (!out_valid);
      got.kind = out_record_kind; got.rank = out_rank; got.split = out_split;
      got.lower = out_band_lower; got.upper = out_band_upper;
      got.width = out_band_width; got.mask = out_direction_mask;
      got.ovf = out_overflow; got.bad = out_bad_input; got.last = out_run_end;
      @(posedge clk);
      sb.check_result(got);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_item(32'h0001_0000, 32'h0002_0000, 1, 1);
    set_road(32'hFFFB_0000, 32'h0005_0000, 2'd3);
    send_item('0, '0, 0, 1);
    send_item('0, '0, 0, 0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
    send_item(32'h8000_0000, 32'h8000_0000, 1, 0);
    send_item(32'h0001_0000, 32'h0002_0000, 1, 1);
    send_item(32'h0001_0000, 32'h0003_0000, 1, 0);
    send_item(32'h0001_0000, 32'h0003_0000, 1, 0);
    send_item(32'h0001_0000, 32'h0004_0000, 1, 0);
    send_item(32'hFFFE_0000, 32'hFFFF_0000, 1, 0);
    send_item('0, '0, 0, 1);
    send_item(32'h0003_0000, 32'h0001_0000, 1, 1);
    set_road(32'hFFFB_0000, 32'h0005_0000, 2'd0);
    send_item(32'hFFFF_0000, 32'h0001_0000, 1, 0);
    send_item(32'h0002_0000, 32'h0003_0000, 1, 1);
    set_road(32'h0005_0000, 32'hFFFB_0000, 2'd1);
    send_item(32'h0000_0000, 32'h0001_0000, 1, 1);
    send_item(32'h0002_0000, 32'h0003_0000, 1, 1);
    set_road(32'h8000_0000, 32'h7FFF_FFFF, 2'd3);
    while (random_items < 80) begin
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(3))
          0: set_road(32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(3));
          1: set_road(32'hFFF0_0000, 32'h0010_0000, $urandom_range(3));
          2: set_road($urandom(), $urandom(), $urandom_range(3));
          default: set_road(32'h0000_0000, 32'h0008_0000, 2'd3);
        endcase
      end
      random_case();
    end
    settle();
    $display("tb: %0d cases, %0d band records checked across road and limit settings",
             sb.cases, sb.checked);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
